@@ src/swsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader package
// Shared types, register indexes, reset values and the sign-magnitude helper.
// ----------------------------------------------------------------------------
package swsr_pkg;

    // Protocol phases of one reading
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRE_HIGH  = 3'd1,
        PH_START_LOW = 3'd2,
        PH_RELEASE   = 3'd3,
        PH_RESP_LOW  = 3'd4,
        PH_RESP_HIGH = 3'd5,
        PH_BIT_WAIT  = 3'd6,
        PH_MEASURE   = 3'd7
    } phase_t;

    // Status codes of a finished reading
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_HIGH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_THR   = 3'd4;

    localparam int unsigned CFG_DATA_W = 18;

    // Register reset values
    localparam logic [17:0] IDLE_HIGH_RESET = 18'd250000;
    localparam logic [15:0] START_LOW_RESET = 16'd20000;
    localparam logic [15:0] RELEASE_RESET   = 16'd40;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
    localparam logic [7:0]  ONE_THR_RESET   = 8'd40;

    // Number of data bits in one frame
    localparam logic [5:0] FRAME_BITS = 6'd40;

    // Configuration register set
    typedef struct packed {
        logic [17:0] idle_high_ticks;
        logic [15:0] start_low_ticks;
        logic [15:0] release_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  one_threshold_ticks;
    } cfg_t;

    // One input tick
    typedef struct packed {
        logic line_in;
        logic start_req;
    } item_t;

    // One result item
    typedef struct packed {
        logic signed [15:0] humidity;
        logic signed [15:0] temperature;
        logic [1:0]         status;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } result_t;

    // Sign-magnitude byte pair to signed tenths; negative zero gives zero.
    function automatic logic [15:0] to_tenths(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] mag;
        mag = {1'b0, hi[6:0], lo};
        return hi[7] ? (16'd0 - mag) : mag;
    endfunction

endpackage

@@ src/swsr_cfg.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader configuration registers
// Holds the five timing registers written through the configuration channel.
// ----------------------------------------------------------------------------
module swsr_cfg
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]       cfg_data,
    output swsr_pkg::cfg_t                        cfg
);

    swsr_pkg::cfg_t cfg_reg;
    logic           wr_en;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_high_ticks     <= swsr_pkg::IDLE_HIGH_RESET;
            cfg_reg.start_low_ticks     <= swsr_pkg::START_LOW_RESET;
            cfg_reg.release_ticks       <= swsr_pkg::RELEASE_RESET;
            cfg_reg.timeout_ticks       <= swsr_pkg::TIMEOUT_RESET;
            cfg_reg.one_threshold_ticks <= swsr_pkg::ONE_THR_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                swsr_pkg::CFG_IDLE_HIGH: cfg_reg.idle_high_ticks     <= cfg_data[17:0];
                swsr_pkg::CFG_START_LOW: cfg_reg.start_low_ticks     <= cfg_data[15:0];
                swsr_pkg::CFG_RELEASE:   cfg_reg.release_ticks       <= cfg_data[15:0];
                swsr_pkg::CFG_TIMEOUT:   cfg_reg.timeout_ticks       <= cfg_data[15:0];
                swsr_pkg::CFG_ONE_THR:   cfg_reg.one_threshold_ticks <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

@@ src/swsr_core.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader protocol core
// Advances the reading by one tick per step and forms the result of that tick.
// ----------------------------------------------------------------------------
module swsr_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  swsr_pkg::item_t    item,
    input  swsr_pkg::cfg_t     cfg,
    output swsr_pkg::result_t  result
);

    swsr_pkg::phase_t   phase_reg, phase_next;
    logic [17:0]        tick_count_reg, tick_count_next;
    logic [5:0]         bit_index_reg, bit_index_next;
    logic [39:0]        frame_shift_reg, frame_shift_next;
    logic [15:0]        temperature_reg, temperature_next;
    logic [15:0]        humidity_reg, humidity_next;
    logic [1:0]         status_reg, status_next;
    logic               done_flag;

    logic [18:0]        tick_wide;
    logic [17:0]        tick_inc;
    logic [17:0]        duration;
    logic               timed_done;
    logic               wait_expired;
    logic               pulse_expired;
    logic               bit_one;
    logic [39:0]        frame_shifted;
    logic [5:0]         bit_index_inc;
    logic [9:0]         byte_sum;
    logic               checksum_ok;

    // Tick counter arithmetic and the comparisons every phase needs
    always_comb
    begin
        tick_wide     = {1'b0, tick_count_reg} + 19'd1;
        tick_inc      = tick_wide[17:0];
        case (phase_reg)
            swsr_pkg::PH_PRE_HIGH:  duration = cfg.idle_high_ticks;
            swsr_pkg::PH_START_LOW: duration = {2'b00, cfg.start_low_ticks};
            default:                duration = {2'b00, cfg.release_ticks};
        endcase
        timed_done    = (tick_inc >= duration);
        wait_expired  = (tick_wide >= {3'b000, cfg.timeout_ticks});
        pulse_expired = (tick_count_reg >= {2'b00, cfg.timeout_ticks});
        bit_one       = (tick_count_reg > {10'd0, cfg.one_threshold_ticks});
        // The first falling edge ends the response pulse and shifts nothing.
        frame_shifted = (bit_index_reg != 6'd0) ? {frame_shift_reg[38:0], bit_one}
                                                : frame_shift_reg;
        bit_index_inc = bit_index_reg + 6'd1;
        byte_sum      = {2'b00, frame_shifted[39:32]} + {2'b00, frame_shifted[31:24]}
                      + {2'b00, frame_shifted[23:16]} + {2'b00, frame_shifted[15:8]};
        checksum_ok   = (byte_sum[7:0] == frame_shifted[7:0]);
    end

    // Next state of the reading
    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        frame_shift_next = frame_shift_reg;
        temperature_next = temperature_reg;
        humidity_next    = humidity_reg;
        status_next      = status_reg;
        done_flag        = 1'b0;

        case (phase_reg)
            swsr_pkg::PH_IDLE:
            begin
                if (item.start_req)
                begin
                    phase_next       = swsr_pkg::PH_PRE_HIGH;
                    tick_count_next  = 18'd0;
                    bit_index_next   = 6'd0;
                    frame_shift_next = 40'd0;
                end
            end
            swsr_pkg::PH_PRE_HIGH, swsr_pkg::PH_START_LOW, swsr_pkg::PH_RELEASE:
            begin
                if (timed_done)
                begin
                    phase_next      = swsr_pkg::phase_t'(phase_reg + 3'd1);
                    tick_count_next = 18'd0;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            swsr_pkg::PH_RESP_LOW:
            begin
                if (!item.line_in)
                begin
                    phase_next      = swsr_pkg::PH_RESP_HIGH;
                    tick_count_next = 18'd0;
                end
                else if (wait_expired)
                begin
                    phase_next      = swsr_pkg::PH_IDLE;
                    tick_count_next = 18'd0;
                    bit_index_next  = 6'd0;
                    status_next     = swsr_pkg::ST_TIMEOUT;
                    done_flag       = 1'b1;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            swsr_pkg::PH_RESP_HIGH, swsr_pkg::PH_BIT_WAIT:
            begin
                if (item.line_in)
                begin
                    phase_next      = swsr_pkg::PH_MEASURE;
                    tick_count_next = 18'd1;
                    if (phase_reg == swsr_pkg::PH_RESP_HIGH)
                    begin
                        bit_index_next = 6'd0;
                    end
                end
                else if (wait_expired)
                begin
                    phase_next      = swsr_pkg::PH_IDLE;
                    tick_count_next = 18'd0;
                    bit_index_next  = 6'd0;
                    status_next     = swsr_pkg::ST_TIMEOUT;
                    done_flag       = 1'b1;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            swsr_pkg::PH_MEASURE:
            begin
                if (item.line_in)
                begin
                    if (pulse_expired)
                    begin
                        phase_next      = swsr_pkg::PH_IDLE;
                        tick_count_next = 18'd0;
                        bit_index_next  = 6'd0;
                        status_next     = swsr_pkg::ST_TIMEOUT;
                        done_flag       = 1'b1;
                    end
                    else
                    begin
                        tick_count_next = tick_inc;
                    end
                end
                else
                begin
                    frame_shift_next = frame_shifted;
                    if (bit_index_inc > swsr_pkg::FRAME_BITS)
                    begin
                        // Whole frame in: check and decode it.
                        phase_next      = swsr_pkg::PH_IDLE;
                        tick_count_next = 18'd0;
                        bit_index_next  = 6'd0;
                        done_flag       = 1'b1;
                        if (checksum_ok)
                        begin
                            humidity_next    = swsr_pkg::to_tenths(frame_shifted[39:32],
                                                                   frame_shifted[31:24]);
                            temperature_next = swsr_pkg::to_tenths(frame_shifted[23:16],
                                                                   frame_shifted[15:8]);
                            status_next      = swsr_pkg::ST_OK;
                        end
                        else
                        begin
                            status_next = swsr_pkg::ST_CHECKSUM;
                        end
                    end
                    else
                    begin
                        phase_next      = swsr_pkg::PH_BIT_WAIT;
                        tick_count_next = 18'd0;
                        bit_index_next  = bit_index_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers, advanced once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= swsr_pkg::PH_IDLE;
            tick_count_reg  <= 18'd0;
            bit_index_reg   <= 6'd0;
            frame_shift_reg <= 40'd0;
            temperature_reg <= 16'd0;
            humidity_reg    <= 16'd0;
            status_reg      <= swsr_pkg::ST_OK;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            frame_shift_reg <= frame_shift_next;
            temperature_reg <= temperature_next;
            humidity_reg    <= humidity_next;
            status_reg      <= status_next;
        end
    end

    // Result of this tick reflects the state after it
    always_comb
    begin
        result.drive_low   = (phase_next == swsr_pkg::PH_START_LOW);
        result.busy_res    = (phase_next != swsr_pkg::PH_IDLE);
        result.done_res    = done_flag;
        result.status      = status_next;
        result.temperature = temperature_next;
        result.humidity    = humidity_next;
    end

endmodule

@@ src/single_wire_sensor_reader.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader
// Reads temperature and humidity from a single-wire sensor, one tick per item.
// ----------------------------------------------------------------------------
// Each slave-side transfer is one microsecond tick with a start request and
// the sampled data line; each produces exactly one master-side result with the
// line drive, busy, done, status and the held temperature and humidity. The
// block sustains one tick per clock cycle while results are taken: a tick is
// captured in an input register at its transfer, and the combinational protocol
// logic fills the result register from it when that register is free or draining;
// the master side offers the result from there. While a
// result waits, the input register takes one more tick; after that the slave
// side stalls until the waiting result is taken.
// Configuration writes take effect at once and should be made while idle.
module single_wire_sensor_reader
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Tick input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // start_req, line_in, zero pad

    // Result output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [39:0]                           m_tdata,   // drive_low, busy_res, done_res,
                                                             // status[1:0], temperature[15:0],
                                                             // humidity[15:0], zero pad

    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    swsr_pkg::cfg_t     cfg;
    swsr_pkg::item_t    in_item_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    swsr_pkg::result_t  out_result_reg;
    swsr_pkg::result_t  step_result;
    logic               advance;

    // A held tick moves on when the result register is free or draining.
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    swsr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swsr_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.start_req <= s_tdata[0];
            in_item_reg.line_in   <= s_tdata[1];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.humidity,
                       out_result_reg.temperature,
                       out_result_reg.status,
                       out_result_reg.done_res,
                       out_result_reg.busy_res,
                       out_result_reg.drive_low};

endmodule
